// File: sv/sqpm_pkg.sv
// ----------------------------------------------------------------------------
// sqpm_pkg: shared types and constants for the sorted priority queue
// Capacity, field widths, command and status codes, and the structs that
// pass between the sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
package sqpm_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_PLACE,
    ST_REM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;
  } res_t;

endpackage

// File: sv/sqpm_in_if.sv
// ----------------------------------------------------------------------------
// sqpm_in_if: command channel of the sorted priority queue
// Valid/ready channel carrying one insert or remove command per item.
// ----------------------------------------------------------------------------
interface sqpm_in_if;
  import sqpm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// File: sv/sqpm_out_if.sv
// ----------------------------------------------------------------------------
// sqpm_out_if: result channel of the sorted priority queue
// Valid/ready channel carrying status, removed value and entry count.
// ----------------------------------------------------------------------------
interface sqpm_out_if;
  import sqpm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] removed_value;
  logic [COUNT_W-1:0]        entry_count;

  modport source (output valid, output status, output removed_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input entry_count, output ready);
endinterface

// File: sv/sqpm_mem.sv
// ----------------------------------------------------------------------------
// sqpm_mem: entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sqpm_mem (
  input  logic                      clk,
  input  sqpm_pkg::mem_req_t        req,
  output logic [sqpm_pkg::VALUE_W-1:0] rd_data
);
  import sqpm_pkg::*;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;
endmodule

// File: sv/sqpm_cmp.sv
// ----------------------------------------------------------------------------
// sqpm_cmp: shared signed comparator
// Flags a stored entry that is strictly greater than the new value.
// ----------------------------------------------------------------------------
module sqpm_cmp (
  input  logic [sqpm_pkg::VALUE_W-1:0] entry,
  input  logic [sqpm_pkg::VALUE_W-1:0] value,
  output logic                         gt
);
  import sqpm_pkg::*;

  assign gt = $signed(entry) > $signed(value);
endmodule

// File: sv/sqpm_ctrl.sv
// ----------------------------------------------------------------------------
// sqpm_ctrl: insert/remove sequencer
// Walks the store from the top, one entry per cycle, shifting larger entries
// up until the slot for the new value is found; pops the top on remove.
// ----------------------------------------------------------------------------
module sqpm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_cmd,
  input  logic [sqpm_pkg::VALUE_W-1:0] in_value,
  output logic                         in_ready,
  output sqpm_pkg::mem_req_t           mem_req,
  input  logic [sqpm_pkg::VALUE_W-1:0] rd_data,
  output logic [sqpm_pkg::VALUE_W-1:0] cmp_value,
  input  logic                         cmp_gt,
  input  logic                         out_free,
  output logic                         res_valid,
  output sqpm_pkg::res_t               res
);
  import sqpm_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  status_t            status_r, status_nxt;
  logic [VALUE_W-1:0] removed_r, removed_nxt;
  logic [CNT_W-1:0]   occ_dec, occ_inc, k_dec, k_dec2;
  logic               occ_zero, occ_full;

  assign occ_dec  = occ_r - CNT_W'(1);
  assign occ_inc  = occ_r + CNT_W'(1);
  assign k_dec    = k_r - CNT_W'(1);
  assign k_dec2   = k_r - CNT_W'(2);
  assign occ_zero = (occ_r == '0);
  assign occ_full = (occ_r == CNT_W'(CAPACITY));

  assign cmp_value = value_r;

  always_comb begin : next_state
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_REMOVE) begin
            state_nxt = occ_zero ? ST_OUT : ST_REM;
          end else if (occ_full || occ_zero) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (!cmp_gt) begin
          state_nxt = ST_OUT;
        end else if (k_dec == '0) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: state_nxt = ST_OUT;
      ST_REM:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin : outputs
    in_ready      = (state_r == ST_IDLE);
    mem_req.we    = 1'b0;
    mem_req.waddr = k_r[ADDR_W-1:0];
    mem_req.wdata = value_r;
    mem_req.raddr = k_dec2[ADDR_W-1:0];
    occ_nxt       = occ_r;
    k_nxt         = k_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    res_valid     = 1'b0;
    res.status        = status_r;
    res.removed_value = removed_r;
    res.entry_count   = COUNT_W'(occ_r);
    unique case (state_r)
      ST_IDLE: begin
        // Prefetch the top entry; both insert and remove start there.
        mem_req.raddr = occ_dec[ADDR_W-1:0];
        if (in_valid) begin
          value_nxt   = in_value;
          removed_nxt = '0;
          status_nxt  = STATUS_DONE;
          k_nxt       = occ_r;
          if (in_cmd == CMD_REMOVE) begin
            if (occ_zero) begin
              status_nxt = STATUS_EMPTY;
            end else begin
              occ_nxt = occ_dec;
            end
          end else if (occ_full) begin
            status_nxt = STATUS_FULL;
          end else if (occ_zero) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = in_value;
            occ_nxt       = occ_inc;
          end
        end
      end
      ST_CMP: begin
        mem_req.we = 1'b1;
        if (cmp_gt) begin
          // Shift the larger entry up one slot and look one lower.
          mem_req.wdata = rd_data;
          k_nxt         = k_dec;
        end else begin
          occ_nxt = occ_inc;
        end
      end
      ST_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        occ_nxt       = occ_inc;
      end
      ST_REM: begin
        removed_nxt = rd_data;
      end
      ST_OUT: begin
        res_valid = out_free;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    value_r   <= value_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end
endmodule

// File: sv/sorted_insert_queue_pop_max.sv
// ----------------------------------------------------------------------------
// sorted_insert_queue_pop_max: bounded sorted priority queue
// Keeps up to CAPACITY signed values in ascending order; insert or pop max.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one command per item: cmd 0 inserts value after every
//          stored entry not greater than it, cmd 1 removes the largest entry.
//   out_ch returns exactly one item per command: status (done, remove on
//          empty, insert on full dropped), the removed value (zero unless a
//          remove succeeded) and the entry count after the command.
// Sequencing:
//   One shared comparator and a store with one write and one read port, one
//   entry per cycle. An insert walks compare states down from the top and
//   writes in the last compare or a place state; a remove has a read state;
//   full and empty cases skip to output. in_ch.ready is high only while idle,
//   so the next item is taken the cycle after the result is registered.
// Reset:
//   rst_n clears the count, the sequencer and the output valid. Store
//   contents are not cleared; only entries below the count are ever used.
// Stall:
//   A registered result waits for out_ch.ready while the next item is
//   accepted; its result is held in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module sorted_insert_queue_pop_max (
  input  logic              clk,
  input  logic              rst_n,
  sqpm_in_if.sink           in_ch,
  sqpm_out_if.source        out_ch
);
  import sqpm_pkg::*;

  mem_req_t           mem_req;
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] cmp_value;
  logic               cmp_gt;
  logic               out_free;
  logic               res_valid;
  res_t               res;
  logic               out_valid_r;
  res_t               out_res_r;

  // Result slot frees when empty or when its item leaves this cycle.
  assign out_free = !out_valid_r || out_ch.ready;

  sqpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_value  (in_ch.value),
    .in_ready  (in_ch.ready),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .cmp_value (cmp_value),
    .cmp_gt    (cmp_gt),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  sqpm_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  sqpm_cmp u_cmp (
    .entry (rd_data),
    .value (cmp_value),
    .gt    (cmp_gt)
  );

  // Output register: load a fresh result, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.removed_value = out_res_r.removed_value;
  assign out_ch.entry_count   = out_res_r.entry_count;

  // A remove on an empty store leaves nothing stored and returns zero.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STATUS_EMPTY)
      |-> (out_ch.entry_count == '0 && out_ch.removed_value == '0))
    else $error("empty-store result carries a count or value");

  // A dropped insert never reports a removed value.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STATUS_FULL)
      |-> (out_ch.removed_value == '0))
    else $error("full-store result carries a removed value");

  // The sequencer is busy on the cycle after an accepted item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready on the cycle after an accept");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !res_valid)
    else $error("result loaded over a stalled result");
endmodule

// File: tb/tb_sorted_insert_queue_pop_max.sv
// ----------------------------------------------------------------------------
// tb_sorted_insert_queue_pop_max: self-checking bench for the sorted queue
// Drives insert and remove commands over the valid/ready command channel,
// predicts every result with a queue model of its own, and compares status,
// removed value and entry count of each returned item in order. A short
// table of directed commands comes first, then about 1500 random commands
// in fill, drain and balanced phases with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_insert_queue_pop_max;
  import sqpm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // slowest correct run is far below this
  localparam int TAIL_CYCLES = 24;      // a full shift plus overhead
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 125;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Result of one command as the queue model sees it.
  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] removed;
    logic [COUNT_W-1:0]        count;
  } queue_result_t;

  // One row of the directed table; known rows carry a hand-written result.
  typedef struct {
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] value;
    bit                        known;
    queue_result_t             fixed;
  } directed_row_t;

  // Hand-written result handed from the sender to the acceptance monitor.
  typedef struct {
    bit            known;
    queue_result_t fixed;
  } preset_t;

  logic clk;
  logic rst_n;

  sqpm_in_if  in_ch ();
  sqpm_out_if out_ch ();

  sorted_insert_queue_pop_max DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model state: stored values in ascending order, oldest equal value first.
  logic signed [VALUE_W-1:0] model_entries[$];

  queue_result_t  expected_results[$];
  preset_t        pending_presets[$];
  directed_row_t  directed_rows[$];
  queue_result_t  no_preset;

  int  mismatches;
  int  cycle_count;
  int  sink_wait;
  bit  idle_mode;
  int  n_insert, n_remove, n_full, n_empty, n_results, peak_count;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // End the run if results stop coming; nothing should ever get close.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Queue model: apply one command, return the result it should produce.
  // --------------------------------------------------------------------------
  function automatic queue_result_t predict_queue_result(
      input cmd_t c, input logic signed [VALUE_W-1:0] v);
    queue_result_t r;
    int            pos;
    r.status  = STATUS_DONE;
    r.removed = '0;
    if (c == CMD_INSERT) begin
      if (model_entries.size() >= CAPACITY) begin
        // drop the value, leave the store alone
        r.status = STATUS_FULL;
      end else begin
        // walk past every entry not greater than v so equal values keep order
        pos = 0;
        while (pos < model_entries.size() && !(model_entries[pos] > v)) pos++;
        model_entries.insert(pos, v);
      end
    end else begin
      if (model_entries.size() == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        // largest value sits at the tail
        r.removed = model_entries.pop_back();
      end
    end
    r.count = COUNT_W'(model_entries.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict at command acceptance, check at result acceptance.
  // Both channels are sampled at the edge, before any driver update lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    preset_t       p;
    queue_result_t pred;
    queue_result_t want;
    if (rst_n) begin
      // check the returned item against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d value=%0d count=%0d",
                                    out_ch.status, out_ch.removed_value,
                                    out_ch.entry_count));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d", n_results,
                                      out_ch.status, want.status));
          if (out_ch.removed_value !== want.removed)
            report_mismatch($sformatf("result %0d removed_value %0d, want %0d",
                                      n_results, out_ch.removed_value, want.removed));
          if (out_ch.entry_count !== want.count)
            report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                      n_results, out_ch.entry_count, want.count));
        end
      end
      // advance the model for the command taken at this edge
      if (in_ch.valid && in_ch.ready) begin
        p    = pending_presets.pop_front();
        pred = predict_queue_result(cmd_t'(in_ch.cmd), in_ch.value);
        expected_results.push_back(p.known ? p.fixed : pred);
        if (in_ch.cmd == CMD_INSERT) n_insert++;
        else n_remove++;
        if (pred.status == STATUS_FULL) n_full++;
        if (pred.status == STATUS_EMPTY) n_empty++;
        if (model_entries.size() > peak_count) peak_count = model_entries.size();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: after each taken item, drop ready for a random wait when idling is on.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_wait = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sink_wait = idle_mode ? $urandom_range(0, 4) : 0;
      else if (sink_wait > 0) sink_wait--;
      out_ch.ready <= (sink_wait == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Command sender
  // --------------------------------------------------------------------------
  // Present one item after a random gap and hold it until it is taken.
  // Valid stays high across back-to-back items, so it is written once per step.
  task automatic send_item(input cmd_t c, input logic signed [VALUE_W-1:0] v,
                           input bit known, input queue_result_t fixed);
    int      gap;
    preset_t p;
    gap = idle_mode ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.known = known;
    p.fixed = fixed;
    pending_presets.push_back(p);
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the sender until every result due has come back. Step one edge
  // first so the monitor has logged the item taken at the current edge.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic directed_row_t row(input cmd_t c, input logic signed [VALUE_W-1:0] v,
                                        input bit known, input status_t s,
                                        input logic signed [VALUE_W-1:0] rem,
                                        input logic [COUNT_W-1:0] cnt);
    directed_row_t r;
    r.cmd           = c;
    r.value         = v;
    r.known         = known;
    r.fixed.status  = s;
    r.fixed.removed = rem;
    r.fixed.count   = cnt;
    return r;
  endfunction

  // Mix of full-range values, a narrow band that makes many ties, and extremes.
  function automatic logic signed [VALUE_W-1:0] draw_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      1: begin
        v = $urandom_range(0, 16);
        v = v - 8;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int   phase;
    int   k;
    int   insert_pct;
    cmd_t c;

    no_preset.status  = STATUS_DONE;
    no_preset.removed = '0;
    no_preset.count   = '0;

    // known values on the command inputs from the first step
    rst_n        <= 1'b0;
    idle_mode    <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_INSERT;
    in_ch.value  <= '0;

    // Directed table. Rows marked known carry a result read off by hand:
    // remove on an empty store, the two extremes, insert on a full store and
    // the removes of the maximum. The rest go through the model.
    directed_rows.push_back(row(CMD_REMOVE, VAL_MAX, 1, STATUS_EMPTY, 0, 0));
    directed_rows.push_back(row(CMD_INSERT, VAL_MIN, 1, STATUS_DONE,  0, 1));
    directed_rows.push_back(row(CMD_INSERT, VAL_MAX, 1, STATUS_DONE,  0, 2));
    directed_rows.push_back(row(CMD_REMOVE, '0,      1, STATUS_DONE,  VAL_MAX, 1));
    directed_rows.push_back(row(CMD_INSERT, VAL_MAX, 0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 0,       0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, -1,      0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 1,       0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 5,       0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 5,       0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 5,       0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 32'sh5555_5555, 0, STATUS_DONE, 0, 0));
    directed_rows.push_back(row(CMD_INSERT, 32'shAAAA_AAAA, 0, STATUS_DONE, 0, 0));
    directed_rows.push_back(row(CMD_INSERT, VAL_MIN, 0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, -2,      0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 2,       0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 100,     0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, -100,    0, STATUS_DONE,  0, 0));
    directed_rows.push_back(row(CMD_INSERT, 7,       0, STATUS_DONE,  0, 0));
    // store is full now
    directed_rows.push_back(row(CMD_INSERT, 3,       1, STATUS_FULL,  0,
                                COUNT_W'(CAPACITY)));
    directed_rows.push_back(row(CMD_REMOVE, '0,      1, STATUS_DONE,  VAL_MAX,
                                COUNT_W'(CAPACITY - 1)));
    directed_rows.push_back(row(CMD_INSERT, VAL_MAX, 0, STATUS_DONE,  0, 0));
    // value on a remove is ignored
    directed_rows.push_back(row(CMD_REMOVE, -1,      1, STATUS_DONE,  VAL_MAX,
                                COUNT_W'(CAPACITY - 1)));
    directed_rows.push_back(row(CMD_REMOVE, VAL_MIN, 0, STATUS_DONE,  0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].value,
                directed_rows[i].known, directed_rows[i].fixed);

    // let everything land before the random part
    drain_results();

    // Random part: fill, drain and balanced phases so the store keeps
    // running into both its full and its empty edge. Every fourth phase
    // runs with no idling on either side.
    for (phase = 0; phase < PHASES; phase++) begin
      idle_mode <= (phase % 4 != 3);
      case (phase % 3)
        0:       insert_pct = 75;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        c = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        send_item(c, draw_value(), 0, no_preset);
      end
      drain_results();
    end

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // give a stray extra result time to show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d dropped on full) and %0d removes (%0d on empty)",
             n_insert, n_full, n_remove, n_empty);
    $display("peak depth %0d of %0d, %0d results checked, %0d mismatches",
             peak_count, CAPACITY, n_results, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
sv/sqpm_pkg.sv
sv/sqpm_in_if.sv
sv/sqpm_out_if.sv
sv/sqpm_mem.sv
sv/sqpm_cmp.sv
sv/sqpm_ctrl.sv
sv/sorted_insert_queue_pop_max.sv
tb/tb_sorted_insert_queue_pop_max.sv
